// ===== rtl/tcm_pkg.sv =====
// Shared types and constants for the trimmed, clamped median block.
// No dependencies; every other file of the block imports this package.
package tcm_pkg;

  localparam int unsigned MAX_POINTS_DEF = 1024;

  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned VAL_W    = 17;
  localparam int unsigned TRIM_W   = 3;
  localparam int unsigned BIT_W    = 5;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 17;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_TRIM_BOTTOM = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIM_TOP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLAMP_LOW   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLAMP_HIGH  = 2'd3;

  localparam logic [TRIM_W-1:0] TRIM_RESET      = 3'd1;
  localparam logic [VAL_W-1:0]  CLAMP_LOW_RESET  = 17'd0;
  localparam logic [VAL_W-1:0]  CLAMP_HIGH_RESET = 17'd65536;
  localparam logic [VAL_W-1:0]  VAL_MAX          = 17'h1FFFF;

  // floor(x/10) = (x * RECIP) >> RECIP_SHIFT, exact for x below 2^20
  localparam int unsigned RECIP_W     = 20;
  localparam logic [RECIP_W-1:0] RECIP = 20'd838861;
  localparam int unsigned RECIP_SHIFT = 23;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;        // request accepted, store the sample
    logic trim_mul;    // trim tenths times sample count
    logic trim_div;    // divide the products by ten
    logic win_set;     // settle the window end
    logic count_start; // open the counting pass
    logic count_run;
    logic bit_start;   // open one bit-decision pass
    logic bit_run;
    logic bit_update;  // take the decision of the finished bit pass
    logic finish;      // write the result register, restart the profile
  } tcm_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic pass_done;
    logic cnt_zero;
    logic bit_last;
    logic out_hold;
  } tcm_sts_t;

endpackage

// ===== rtl/tcm_in_if.sv =====
// Request channel carrying one profile sample.
// Depends on tcm_pkg for field widths.
interface tcm_in_if import tcm_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       finite;
  logic                       last;

  modport source (output valid, sample, finite, last, input ready);
  modport sink   (input valid, sample, finite, last, output ready);
endinterface

// ===== rtl/tcm_out_if.sv =====
// Result channel carrying the median of one profile.
// Depends on tcm_pkg for field widths.
interface tcm_out_if import tcm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] median;
  logic             empty_res;
  logic             overflowed;

  modport source (output valid, median, empty_res, overflowed, input ready);
  modport sink   (input valid, median, empty_res, overflowed, output ready);
endinterface

// ===== rtl/tcm_ctrl.sv =====
// Controller state machine: sequences loading, window setup and selection passes.
// Depends on tcm_pkg for the command and status structs.
module tcm_ctrl import tcm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_last_i,
  output logic     in_ready_o,
  input  tcm_sts_t sts_i,
  output tcm_cmd_t cmd_o
);

  typedef enum logic [8:0] {
    S_LOAD   = 9'b000000001,
    S_MUL    = 9'b000000010,
    S_DIV    = 9'b000000100,
    S_WIN    = 9'b000001000,
    S_CSTART = 9'b000010000,
    S_COUNT  = 9'b000100000,
    S_BSTART = 9'b001000000,
    S_BPASS  = 9'b010000000,
    S_RESULT = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and command decode
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_last_i) state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.trim_mul = 1'b1;
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.trim_div = 1'b1;
        state_d = S_WIN;
      end
      S_WIN: begin
        cmd_o.win_set = 1'b1;
        state_d = S_CSTART;
      end
      S_CSTART: begin
        cmd_o.count_start = 1'b1;
        state_d = S_COUNT;
      end
      S_COUNT: begin
        cmd_o.count_run = 1'b1;
        if (sts_i.pass_done) begin
          state_d = sts_i.cnt_zero ? S_RESULT : S_BSTART;
        end
      end
      S_BSTART: begin
        cmd_o.bit_start = 1'b1;
        state_d = S_BPASS;
      end
      S_BPASS: begin
        cmd_o.bit_run = 1'b1;
        if (sts_i.pass_done) begin
          cmd_o.bit_update = 1'b1;
          state_d = sts_i.bit_last ? S_RESULT : S_BSTART;
        end
      end
      S_RESULT: begin
        // wait until the result register is free
        if (!sts_i.out_hold) begin
          cmd_o.finish = 1'b1;
          state_d = S_LOAD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

endmodule

// ===== rtl/tcm_dp.sv =====
// Datapath: configuration registers, sample store, window arithmetic,
// bitwise median search and the result register. Depends on tcm_pkg.
module tcm_dp import tcm_pkg::*; #(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration write port
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]      cfg_data_i,
  // request payload
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic                       finite_i,
  // result channel
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [VAL_W-1:0]           median_o,
  output logic                       empty_res_o,
  output logic                       overflowed_o,
  // control
  input  tcm_cmd_t                   cmd_i,
  output tcm_sts_t                   sts_o
);

  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned PW = CW + TRIM_W;
  localparam int unsigned MW = PW + RECIP_W;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_POINTS);
  localparam logic [BIT_W-1:0] TOP_BIT = BIT_W'(VAL_W - 1);

  // Configuration registers
  logic [TRIM_W-1:0] trim_bot_q, trim_top_q;
  logic [VAL_W-1:0]  clamp_lo_q, clamp_hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trim_bot_q <= TRIM_RESET;
      trim_top_q <= TRIM_RESET;
      clamp_lo_q <= CLAMP_LOW_RESET;
      clamp_hi_q <= CLAMP_HIGH_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TRIM_BOTTOM: trim_bot_q <= cfg_data_i[TRIM_W-1:0];
        REG_TRIM_TOP:    trim_top_q <= cfg_data_i[TRIM_W-1:0];
        REG_CLAMP_LOW:   clamp_lo_q <= cfg_data_i[VAL_W-1:0];
        REG_CLAMP_HIGH:  clamp_hi_q <= cfg_data_i[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate the incoming sample to [0, VAL_MAX]
  logic [VAL_W-1:0] sat_val;
  always_comb begin
    if (sample_i[SAMPLE_W-1]) begin
      sat_val = '0;
    end else if (|sample_i[SAMPLE_W-2:VAL_W]) begin
      sat_val = VAL_MAX;
    end else begin
      sat_val = sample_i[VAL_W-1:0];
    end
  end

  // Profile count and overflow flag
  logic [CW-1:0] count_q;
  logic          ovf_q;
  logic          store_en;

  assign store_en = cmd_i.load && (count_q < MAX_CNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else if (cmd_i.finish) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else if (cmd_i.load) begin
      if (store_en) count_q <= count_q + CW'(1);
      else          ovf_q   <= 1'b1;
    end
  end

  // Window bounds: trim products, divide by ten, settle the end
  logic [PW-1:0] prod_bot_q, prod_top_q;
  logic [CW-1:0] win_lo_q, cut_top_q, win_hi_q;
  logic [MW-1:0] quo_bot, quo_top;
  logic [CW-1:0] hi_raw;

  assign quo_bot = MW'(prod_bot_q) * MW'(RECIP);
  assign quo_top = MW'(prod_top_q) * MW'(RECIP);
  assign hi_raw  = count_q - cut_top_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.trim_mul) begin
      prod_bot_q <= PW'(trim_bot_q) * PW'(count_q);
      prod_top_q <= PW'(trim_top_q) * PW'(count_q);
    end
    if (cmd_i.trim_div) begin
      win_lo_q  <= quo_bot[RECIP_SHIFT +: CW];
      cut_top_q <= quo_top[RECIP_SHIFT +: CW];
    end
    if (cmd_i.win_set) begin
      win_hi_q <= (hi_raw < win_lo_q) ? win_lo_q : hi_raw;
    end
  end

  // Sample store: one write port while loading, one registered read port
  logic [VAL_W:0]  mem [MAX_POINTS];
  logic [VAL_W:0]  rd_data_q;
  logic [CW-1:0]   ptr_q;
  logic            rd_vld_q;
  logic            pass_run, pass_start, rd_en;

  assign pass_run   = cmd_i.count_run || cmd_i.bit_run;
  assign pass_start = cmd_i.count_start || cmd_i.bit_start;
  assign rd_en      = pass_run && (ptr_q < win_hi_q);

  always_ff @(posedge clk_i) begin
    if (store_en) mem[count_q[AW-1:0]] <= {finite_i, sat_val};
    if (rd_en)    rd_data_q <= mem[ptr_q[AW-1:0]];
  end

  // Pass pointer and read-valid pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q    <= '0;
      rd_vld_q <= 1'b0;
    end else if (pass_start) begin
      ptr_q    <= win_lo_q;
      rd_vld_q <= 1'b0;
    end else if (pass_run) begin
      rd_vld_q <= rd_en;
      if (rd_en) ptr_q <= ptr_q + CW'(1);
    end
  end

  // Clamp the read value: raise to low bound, then lower to high bound
  logic [VAL_W-1:0] raised, clamped;
  logic             rd_fin;
  assign rd_fin  = rd_vld_q && rd_data_q[VAL_W];
  assign raised  = (rd_data_q[VAL_W-1:0] < clamp_lo_q) ? clamp_lo_q : rd_data_q[VAL_W-1:0];
  assign clamped = (raised > clamp_hi_q) ? clamp_hi_q : raised;

  // Bitwise search for the two middle ranks
  logic [CW-1:0]    fin_cnt_q, cnt_a_q, cnt_b_q, rank_a, rank_b;
  logic [VAL_W-1:0] ans_a_q, ans_b_q, try_a, try_b, bit_mask;
  logic [BIT_W-1:0] bit_q;

  assign bit_mask = VAL_W'(1) << bit_q;
  assign try_a    = ans_a_q | bit_mask;
  assign try_b    = ans_b_q | bit_mask;
  assign rank_a   = (fin_cnt_q - CW'(1)) >> 1;
  assign rank_b   = fin_cnt_q >> 1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.count_start) begin
      fin_cnt_q <= '0;
      ans_a_q   <= '0;
      ans_b_q   <= '0;
      bit_q     <= TOP_BIT;
    end else if (cmd_i.count_run && rd_fin) begin
      fin_cnt_q <= fin_cnt_q + CW'(1);
    end
    if (cmd_i.bit_start) begin
      cnt_a_q <= '0;
      cnt_b_q <= '0;
    end else if (cmd_i.bit_run && rd_fin) begin
      cnt_a_q <= cnt_a_q + CW'(clamped < try_a);
      cnt_b_q <= cnt_b_q + CW'(clamped < try_b);
    end
    if (cmd_i.bit_update) begin
      if (cnt_a_q <= rank_a) ans_a_q <= try_a;
      if (cnt_b_q <= rank_b) ans_b_q <= try_b;
      bit_q <= bit_q - BIT_W'(1);
    end
  end

  // Result register
  logic [VAL_W:0]   mid_sum;
  logic             out_valid_q;
  logic [VAL_W-1:0] median_q;
  logic             empty_q, ovf_out_q;

  assign mid_sum = {1'b0, ans_a_q} + {1'b0, ans_b_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      empty_q   <= (fin_cnt_q == '0);
      median_q  <= (fin_cnt_q == '0) ? '0 : mid_sum[VAL_W:1];
      ovf_out_q <= ovf_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign median_o     = median_q;
  assign empty_res_o  = empty_q;
  assign overflowed_o = ovf_out_q;

  // Status
  assign sts_o.pass_done = !(ptr_q < win_hi_q) && !rd_vld_q;
  assign sts_o.cnt_zero  = (fin_cnt_q == '0);
  assign sts_o.bit_last  = (bit_q == '0);
  assign sts_o.out_hold  = out_valid_q && !out_ready_i;

endmodule

// ===== rtl/trimmed_clamped_median.sv =====
// Top level of the trimmed, clamped median block.
// Depends on tcm_pkg, tcm_in_if, tcm_out_if, tcm_ctrl and tcm_dp.
//
//  channel   | direction | payload                          | handshake
//  ----------+-----------+----------------------------------+-----------
//  req_i     | in        | sample[23:0] s, finite, last     | valid/ready
//  res_o     | out       | median[16:0], empty_res, overflowed | valid/ready
//  cfg       | in        | cfg_we_i, cfg_idx_i[1:0], cfg_data_i[16:0] | write only
//
// Samples are taken one per cycle while a profile loads. After the last sample
// the block is busy with window setup, one counting pass and, if any sample in
// the window is finite, 17 bit-decision passes over the single read port of the
// sample store. Requests are refused during that time; a waiting result stops
// only the writing of the next one, not its loading. Reset needs no clearing pass.
module trimmed_clamped_median import tcm_pkg::*; #(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  tcm_in_if.sink                req_i,
  tcm_out_if.source             res_o
);

  tcm_cmd_t cmd;
  tcm_sts_t sts;

  tcm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_last_i  (req_i.last),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tcm_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .sample_i     (req_i.sample),
    .finite_i     (req_i.finite),
    .out_valid_o  (res_o.valid),
    .out_ready_i  (res_o.ready),
    .median_o     (res_o.median),
    .empty_res_o  (res_o.empty_res),
    .overflowed_o (res_o.overflowed),
    .cmd_i        (cmd),
    .sts_o        (sts)
  );

endmodule
